FILE: design/aff_pkg.sv
// Shared types and constants for the first-fit heap allocator.
// No dependencies; aff_ctrl and the top level refer to it by scoped names.
package aff_pkg;

  localparam int SW_W    = 14;  // request size in words
  localparam int ALIGN_W = 13;  // alignment in bytes

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_FREE    = 2'd1;
  localparam logic [1:0] OP_COMPACT = 2'd2;

  localparam logic REG_HEAP_BASE = 1'b0;  // word index of the base register

  typedef enum logic [3:0] {
    S_INIT0,
    S_INIT1,
    S_IDLE,
    S_AL_SKIP,
    S_AL_FIT,
    S_AL_PAD,
    S_AL_HDR,
    S_AL_TAIL,
    S_FR_WALK,
    S_FR_NEXT,
    S_CP_SKIP,
    S_CP_N,
    S_DONE
  } state_t;

  // largest power of two not above a, at least 4
  function automatic logic [ALIGN_W-1:0] align_pow2(input logic [ALIGN_W-1:0] a);
    logic [ALIGN_W-1:0] al;
    al = ALIGN_W'(4);
    for (int k = 3; k < ALIGN_W; k++) begin
      if (a[k]) al = ALIGN_W'(1) << k;
    end
    return al;
  endfunction

endpackage

FILE: design/aff_req_if.sv
// Request channel of the heap allocator: valid/ready plus the operation fields.
// Uses no package.
interface aff_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [14:0] request_bytes;
  logic [12:0] align_bytes;
  logic        compact_on_fail;
  logic [31:0] release_address;

  modport source (output valid, opcode, request_bytes, align_bytes, compact_on_fail,
                  release_address, input ready);
  modport sink (input valid, opcode, request_bytes, align_bytes, compact_on_fail,
                release_address, output ready);
endinterface

FILE: design/aff_rsp_if.sv
// Result channel of the heap allocator: valid/ready plus address and status.
// Uses no package.
interface aff_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_address;
  logic        success;

  modport source (output valid, data_address, success, input ready);
  modport sink (input valid, data_address, success, output ready);
endinterface

FILE: design/aff_hdr_mem.sv
// Header store: one write port, one read port, registered read data.
// Standalone; no package.
module aff_hdr_mem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int W     = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: design/aff_ctrl.sv
// Allocator sequencer: walks headers in the header store, splits, frees, merges.
// Depends on aff_pkg, aff_req_if, aff_rsp_if and aff_hdr_mem.
module aff_ctrl #(
  parameter int HEAP_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] base,
  aff_req_if.sink     in_ch,
  aff_rsp_if.source   out_ch
);

  localparam int AW = $clog2(HEAP_WORDS);
  localparam int DW = AW + 13;
  localparam int SW_W = aff_pkg::SW_W;
  localparam int AL_W = aff_pkg::ALIGN_W;

  aff_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]   cur_r, cur_nxt, h_r, h_nxt, n_r, n_nxt, hd_r, hd_nxt;
  logic [AW-1:0]   mid_r, mid_nxt, len_r, len_nxt, hint_r, hint_nxt;
  logic [DW-1:0]   d_r, d_nxt;
  logic [SW_W-1:0] sw_r, sw_nxt;
  logic [AL_W-1:0] al_r, al_nxt;
  logic [1:0]      op_r, op_nxt;
  logic            retry_r, retry_nxt, pass_r, pass_nxt;
  logic            pad_big_r, pad_big_nxt, rem2_r, rem2_nxt;
  logic [31:0]     res_addr_r, res_addr_nxt, out_addr_r, out_addr_nxt;
  logic            res_ok_r, res_ok_nxt, out_ok_r, out_ok_nxt;
  logic            out_valid_r, out_valid_nxt;

  // header store port
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [AW:0]   mem_wdata, mem_rdata;

  aff_hdr_mem #(.DEPTH(HEAP_WORDS), .AW(AW), .W(AW + 1)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  function automatic logic [AW-1:0] next_of(input logic [AW-1:0] i, input logic [AW-1:0] l);
    logic [AW:0] s;
    s = {1'b0, i} + {1'b0, l} + (AW+1)'(1);
    if (s > (AW+1)'(HEAP_WORDS - 1)) s = (AW+1)'(HEAP_WORDS - 1);
    return s[AW-1:0];
  endfunction

  // current header
  logic [AW-1:0] hdr_len;
  logic          hdr_used, hdr_end, skip_adv;
  logic [AW-1:0] nxt_cur;
  assign hdr_len  = mem_rdata[AW-1:0];
  assign hdr_used = mem_rdata[AW];
  assign hdr_end  = (hdr_len == '0);
  assign skip_adv = hdr_used && !hdr_end;
  assign nxt_cur  = next_of(cur_r, hdr_len);

  logic in_fire, out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // data slot: first aligned address strictly above the header
  logic [DW-1:0]   cur_w;
  logic [11:0]     lo_sum, lo_msk;
  logic [AL_W-1:0] off_b;
  logic [10:0]     delta0;
  logic [11:0]     delta;
  logic [DW-1:0]   d_calc;
  assign cur_w  = DW'(cur_r);
  assign lo_sum = base[11:0] + {cur_w[9:0], 2'b00};
  assign lo_msk = lo_sum & 12'(al_r - AL_W'(1));
  assign off_b  = al_r - {1'b0, lo_msk};
  assign delta0 = off_b[12:2];
  // single spare word: move to the next aligned slot
  assign delta  = (delta0 == 11'd2) ? 12'(delta0) + 12'(al_r[12:2]) : 12'(delta0);
  assign d_calc = cur_w + DW'(delta);

  logic [DW-1:0] sum_ds;
  logic          fit, rem2_c, pad_big_c;
  assign sum_ds    = d_r + DW'(sw_r);
  assign fit       = sum_ds <= DW'(n_r);
  assign rem2_c    = (sum_ds + DW'(2)) <= DW'(n_r);
  assign pad_big_c = d_r > (DW'(h_r) + DW'(2));

  logic [AW-1:0] hd_calc, hd_len;
  assign hd_calc = pad_big_r ? (d_r[AW-1:0] - AW'(1)) : h_r;
  assign hd_len  = rem2_r ? AW'(sw_r) : (pad_big_r ? (n_r - d_r[AW-1:0]) : len_r);

  logic [31:0] d32, alloc_addr;
  assign d32        = 32'(d_r);
  assign alloc_addr = base + {d32[29:0], 2'b00};

  // free address decode
  logic [31:0] rel_off;
  logic        free_bad;
  logic [AW-1:0] free_hd;
  assign rel_off  = in_ch.release_address - base;
  assign free_bad = (rel_off[1:0] != 2'b00) || (rel_off[31:2] == '0) ||
                    (rel_off[31:2] >= 30'(HEAP_WORDS));
  assign free_hd  = AW'(rel_off[31:2] - 30'd1);

  logic fr_adv, fr_hit, cp_merge;
  logic [AW-1:0] cp_len;
  assign fr_adv   = !hdr_end && (cur_r < hd_r);
  assign fr_hit   = (cur_r == hd_r) && !hdr_end;
  assign cp_merge = !hdr_used && !hdr_end;
  assign cp_len   = len_r + hdr_len + AW'(1);

  // bytes + 3 needs one bit more than the byte field
  logic [SW_W+1:0] req_sum;
  logic [SW_W-1:0] sw_in;
  assign req_sum = {1'b0, in_ch.request_bytes} + (SW_W+2)'(3);
  assign sw_in   = (req_sum[SW_W+1:2] == '0) ? SW_W'(1) : req_sum[SW_W+1:2];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      aff_pkg::S_INIT0: state_nxt = aff_pkg::S_INIT1;
      aff_pkg::S_INIT1: state_nxt = aff_pkg::S_IDLE;
      aff_pkg::S_IDLE: begin
        if (in_fire) begin
          case (in_ch.opcode)
            aff_pkg::OP_ALLOC:   state_nxt = aff_pkg::S_AL_SKIP;
            aff_pkg::OP_FREE:    state_nxt = free_bad ? aff_pkg::S_DONE : aff_pkg::S_FR_WALK;
            aff_pkg::OP_COMPACT: state_nxt = aff_pkg::S_CP_SKIP;
            default:             state_nxt = aff_pkg::S_DONE;
          endcase
        end
      end
      aff_pkg::S_AL_SKIP: begin
        if (skip_adv) state_nxt = aff_pkg::S_AL_SKIP;
        else if (hdr_end) state_nxt = (retry_r && !pass_r) ? aff_pkg::S_CP_SKIP
                                                           : aff_pkg::S_DONE;
        else state_nxt = aff_pkg::S_AL_FIT;
      end
      aff_pkg::S_AL_FIT: state_nxt = fit ? aff_pkg::S_AL_PAD : aff_pkg::S_AL_SKIP;
      aff_pkg::S_AL_PAD: state_nxt = aff_pkg::S_AL_HDR;
      aff_pkg::S_AL_HDR: state_nxt = aff_pkg::S_AL_TAIL;
      aff_pkg::S_AL_TAIL: state_nxt = aff_pkg::S_DONE;
      aff_pkg::S_FR_WALK: begin
        if (fr_adv) state_nxt = aff_pkg::S_FR_WALK;
        else state_nxt = fr_hit ? aff_pkg::S_FR_NEXT : aff_pkg::S_DONE;
      end
      aff_pkg::S_FR_NEXT: state_nxt = aff_pkg::S_DONE;
      aff_pkg::S_CP_SKIP: begin
        if (skip_adv) state_nxt = aff_pkg::S_CP_SKIP;
        else if (hdr_end) state_nxt = (op_r == aff_pkg::OP_ALLOC) ? aff_pkg::S_AL_SKIP
                                                                  : aff_pkg::S_DONE;
        else state_nxt = aff_pkg::S_CP_N;
      end
      aff_pkg::S_CP_N: state_nxt = cp_merge ? aff_pkg::S_CP_N : aff_pkg::S_CP_SKIP;
      aff_pkg::S_DONE: state_nxt = out_free ? aff_pkg::S_IDLE : aff_pkg::S_DONE;
      default: state_nxt = aff_pkg::S_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    cur_nxt = cur_r;  h_nxt = h_r;  n_nxt = n_r;  hd_nxt = hd_r;  mid_nxt = mid_r;
    len_nxt = len_r;  hint_nxt = hint_r;  d_nxt = d_r;  sw_nxt = sw_r;  al_nxt = al_r;
    op_nxt = op_r;  retry_nxt = retry_r;  pass_nxt = pass_r;
    pad_big_nxt = pad_big_r;  rem2_nxt = rem2_r;
    res_addr_nxt = res_addr_r;  res_ok_nxt = res_ok_r;
    out_addr_nxt = out_addr_r;  out_ok_nxt = out_ok_r;
    out_valid_nxt = out_valid_r;
    mem_we = 1'b0;  mem_waddr = cur_r;  mem_wdata = '0;
    in_ch.ready = 1'b0;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      aff_pkg::S_INIT0: begin
        mem_we = 1'b1;  mem_waddr = '0;  mem_wdata = {1'b0, AW'(HEAP_WORDS - 2)};
      end
      aff_pkg::S_INIT1: begin
        mem_we = 1'b1;  mem_waddr = AW'(HEAP_WORDS - 1);  mem_wdata = '0;
      end
      aff_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_fire) begin
          op_nxt = in_ch.opcode;
          sw_nxt = sw_in;
          al_nxt = aff_pkg::align_pow2(in_ch.align_bytes);
          retry_nxt = in_ch.compact_on_fail;
          pass_nxt = 1'b0;
          hd_nxt = free_hd;
          res_addr_nxt = '0;
          res_ok_nxt = 1'b0;
          cur_nxt = (in_ch.opcode == aff_pkg::OP_ALLOC) ? hint_r : '0;
        end
      end
      aff_pkg::S_AL_SKIP: begin
        if (skip_adv) cur_nxt = nxt_cur;
        else if (hdr_end) begin
          if (retry_r && !pass_r) begin
            pass_nxt = 1'b1;
            cur_nxt = '0;
          end
        end else begin
          h_nxt = cur_r;  len_nxt = hdr_len;  n_nxt = nxt_cur;  d_nxt = d_calc;
        end
      end
      aff_pkg::S_AL_FIT: begin
        if (fit) begin
          pad_big_nxt = pad_big_c;  rem2_nxt = rem2_c;  mid_nxt = sum_ds[AW-1:0];
        end else cur_nxt = n_r;
      end
      aff_pkg::S_AL_PAD: begin
        // leading padding becomes a free block
        if (pad_big_r) begin
          mem_we = 1'b1;  mem_waddr = h_r;
          mem_wdata = {1'b0, d_r[AW-1:0] - h_r - AW'(2)};
        end
      end
      aff_pkg::S_AL_HDR: begin
        mem_we = 1'b1;  mem_waddr = hd_calc;  mem_wdata = {1'b1, hd_len};
      end
      aff_pkg::S_AL_TAIL: begin
        if (rem2_r) begin
          mem_we = 1'b1;  mem_waddr = mid_r;
          mem_wdata = {1'b0, n_r - mid_r - AW'(1)};
        end
        if (h_r == hint_r && !pad_big_r) hint_nxt = rem2_r ? mid_r : n_r;
        res_addr_nxt = alloc_addr;
        res_ok_nxt = 1'b1;
      end
      aff_pkg::S_FR_WALK: begin
        if (fr_adv) cur_nxt = nxt_cur;
        else if (fr_hit) begin
          mem_we = 1'b1;  mem_waddr = hd_r;  mem_wdata = {1'b0, hdr_len};
          len_nxt = hdr_len;  n_nxt = nxt_cur;
        end
      end
      aff_pkg::S_FR_NEXT: begin
        if (cp_merge) begin
          mem_we = 1'b1;  mem_waddr = hd_r;  mem_wdata = {1'b0, cp_len};
        end
        if (hd_r < hint_r) hint_nxt = hd_r;
        res_ok_nxt = 1'b1;
      end
      aff_pkg::S_CP_SKIP: begin
        if (skip_adv) cur_nxt = nxt_cur;
        else if (hdr_end) begin
          hint_nxt = '0;
          if (op_r == aff_pkg::OP_ALLOC) cur_nxt = '0;
          else res_ok_nxt = 1'b1;
        end else begin
          len_nxt = hdr_len;  n_nxt = nxt_cur;
        end
      end
      aff_pkg::S_CP_N: begin
        if (cp_merge) begin
          mem_we = 1'b1;  mem_waddr = cur_r;  mem_wdata = {1'b0, cp_len};
          len_nxt = cp_len;  n_nxt = next_of(cur_r, cp_len);
        end else cur_nxt = n_r;
      end
      aff_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;  out_addr_nxt = res_addr_r;  out_ok_nxt = res_ok_r;
        end
      end
      default: ;
    endcase

    // header wanted next cycle: the follower in merge states, else the walk pointer
    mem_raddr = (state_nxt == aff_pkg::S_CP_N || state_nxt == aff_pkg::S_FR_NEXT) ? n_nxt
                                                                                   : cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aff_pkg::S_INIT0;
      hint_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hint_r      <= hint_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r <= cur_nxt;  h_r <= h_nxt;  n_r <= n_nxt;  hd_r <= hd_nxt;  mid_r <= mid_nxt;
    len_r <= len_nxt;  d_r <= d_nxt;  sw_r <= sw_nxt;  al_r <= al_nxt;  op_r <= op_nxt;
    retry_r <= retry_nxt;  pass_r <= pass_nxt;  pad_big_r <= pad_big_nxt;
    rem2_r <= rem2_nxt;  res_addr_r <= res_addr_nxt;  res_ok_r <= res_ok_nxt;
    out_addr_r <= out_addr_nxt;  out_ok_r <= out_ok_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.data_address = out_addr_r;
  assign out_ch.success      = out_ok_r;

endmodule

FILE: design/aligned_first_fit_heap_allocator.sv
// First-fit heap allocator, top level: base address register and sequencer.
// Depends on aff_pkg, aff_req_if, aff_rsp_if, aff_hdr_mem and aff_ctrl.
//
// Usage:
//  - in_ch takes one operation per transfer: allocate, free or compact.
//    out_ch returns exactly one result per operation, in order.
//  - One operation is in flight at a time. Each step reads one block header
//    from the header store (one read port, registered read data), so the
//    time per operation follows the number of headers walked:
//      allocate: each used block is skipped and each free block tried,
//                then the block is split, committed and handed over;
//      free:     the headers before the freed one are walked, then it is
//                freed (a malformed address goes straight to hand over);
//      compact:  used blocks are skipped and free runs merged up to the
//                end sentinel, then the result is handed over.
//    A failed allocate with compact_on_fail adds a compact pass and a
//    second search. The next operation is taken in the cycle after hand over.
//  - Reset sets the base to 0; the sequencer then writes the initial free
//    block and the end sentinel, and in_ch.ready stays low until then.
//  - The result sits in an output register. A new operation is taken while
//    it waits; a second result waits in the sequencer until out_ch drains.
//  - heap_base_address is written over the APB port (byte address 0), its two
//    low bits dropped; write it only while idle, the block does not check.
module aligned_first_fit_heap_allocator #(
  parameter int HEAP_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  aff_req_if.sink     in_ch,
  aff_rsp_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [31:0] base_r, base_nxt;
  logic        cfg_wr;

  assign pready = 1'b1;
  // only word 0 holds a register; anything above it reads as zero
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == aff_pkg::REG_HEAP_BASE);

  always_comb begin
    base_nxt = base_r;
    if (cfg_wr) base_nxt = {pwdata[31:2], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) base_r <= '0;
    else        base_r <= base_nxt;
  end

  assign prdata = (paddr[2] == aff_pkg::REG_HEAP_BASE) ? base_r : '0;

  aff_ctrl #(.HEAP_WORDS(HEAP_WORDS)) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .base   (base_r),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
